### rtl/dwdcg_pkg.sv
// Shared types, constants and the command word layout of the dual waveform DAC command generator.
`default_nettype none

package dwdcg_pkg;

  // Field widths fixed by the command format.
  localparam int CODE_W     = 10;
  localparam int CMD_W      = 16;
  localparam int PERIOD_W   = 16;
  localparam int TRI_X_W    = 16;
  localparam int TRI_DVD_W  = TRI_X_W + CODE_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Depth of the job queue between the front and the back.
  localparam int JOB_Q_DEPTH = 2;

  localparam logic [CODE_W-1:0] CODE_MAX = 10'd1023;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SINE_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRI_PERIOD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BUF_EN      = 2'd2;

  // Register values after reset.
  localparam logic [PERIOD_W-1:0] SINE_PERIOD_RST = 16'd500;
  localparam logic [PERIOD_W-1:0] TRI_PERIOD_RST  = 16'd1000;

  // DAC channel select codes.
  localparam logic CH_SINE = 1'b0;
  localparam logic CH_TRI  = 1'b1;

  // Gain and active-mode bits are always set in the command word.
  localparam logic CMD_GAIN_ONE = 1'b1;
  localparam logic CMD_ACTIVE   = 1'b1;

  // Triangle part of a queued job: the ramp position and a forced-zero flag.
  typedef struct packed {
    logic               zero;
    logic [TRI_X_W-1:0] x;
  } tri_job_t;

  // Pack a DAC command word: channel, buffer, gain, active, code, two zero bits.
  function automatic logic [CMD_W-1:0] cmd_word(input logic ch, input logic buf_en,
                                                input logic [CODE_W-1:0] code);
    return {ch, buf_en, CMD_GAIN_ONE, CMD_ACTIVE, code, 2'b00};
  endfunction

endpackage

`default_nettype wire

### rtl/dwdcg_if.sv
// Handshake channel interfaces for ticks, DAC command words and configuration writes.
`default_nettype none

interface dwdcg_tick_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

interface dwdcg_cmd_if import dwdcg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command_word;
  logic              dac_channel;
  logic [CODE_W-1:0] sample_code;
  logic              last;

  modport source (output valid, output command_word, output dac_channel, output sample_code,
                  output last, input ready);
  modport sink   (input valid, input command_word, input dac_channel, input sample_code,
                  input last, output ready);
endinterface

interface dwdcg_cfg_if import dwdcg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/dwdcg_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module dwdcg_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port; read data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### rtl/dwdcg_queue.sv
// Short job queue that decouples the tick front end from the waveform back end.
`default_nettype none

module dwdcg_queue import dwdcg_pkg::*; #(
  parameter int WIDTH = 33
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output logic                  not_empty
);

  localparam int PTR_W = (JOB_Q_DEPTH > 1) ? $clog2(JOB_Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(JOB_Q_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(JOB_Q_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(JOB_Q_DEPTH);

  logic [WIDTH-1:0] slot_r [JOB_Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];

  // Pointer and fill level update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != FULL_CNT) || pop)
    else $error("job pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("job popped from an empty queue");

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("queue fill level beyond its depth");

endmodule

`default_nettype wire

### rtl/dwdcg_front.sv
// Front end: accepts tick words, keeps both phase counters and queues one job per tick.
`default_nettype none

module dwdcg_front import dwdcg_pkg::*; #(
  parameter int PHASE_WIDTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  dwdcg_tick_if.sink                  in_ch,
  input  wire logic [PERIOD_W-1:0]    sine_period,
  input  wire logic [PERIOD_W-1:0]    tri_period,
  input  wire logic                   init_done,
  input  wire logic                   q_full,
  output logic                        q_push,
  output logic      [PHASE_WIDTH-1:0] q_phase,
  output tri_job_t                    q_tri
);

  // Compare width wide enough for both a phase and a period.
  localparam int CW = (PHASE_WIDTH > PERIOD_W) ? PHASE_WIDTH : PERIOD_W;

  logic [PHASE_WIDTH-1:0] sphase_r, sphase_nxt;
  logic [PHASE_WIDTH-1:0] tphase_r, tphase_nxt;
  logic [PHASE_WIDTH-1:0] sphase_inc, tphase_inc;
  logic [PERIOD_W-2:0]    tri_half;
  logic [CW-1:0]          tphase_ext, tperiod_ext, tri_x_full;
  logic                   accept;

  assign in_ch.ready = init_done && !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  // A word with the tick bit low is taken and dropped.
  assign q_push      = accept && in_ch.tick;

  // Classify the triangle position: rising half, falling half or forced zero.
  assign tri_half    = tri_period[PERIOD_W-1:1];
  assign tphase_ext  = CW'(tphase_r);
  assign tperiod_ext = CW'(tri_period);
  assign tri_x_full  = (tphase_ext < CW'(tri_half)) ? tphase_ext
                                                     : tperiod_ext - CW'(1) - tphase_ext;

  assign q_phase    = sphase_r;
  assign q_tri.zero = (tri_half < (PERIOD_W-1)'(2)) || (tphase_ext >= tperiod_ext);
  assign q_tri.x    = tri_x_full[TRI_X_W-1:0];

  // Phase advance: step by one and wrap to zero at the period or on overflow.
  assign sphase_inc = sphase_r + 1'b1;
  assign tphase_inc = tphase_r + 1'b1;

  always_comb begin
    sphase_nxt = sphase_r;
    tphase_nxt = tphase_r;
    if (q_push) begin
      sphase_nxt = (CW'(sphase_inc) >= CW'(sine_period)) ? '0 : sphase_inc;
      tphase_nxt = (CW'(tphase_inc) >= tperiod_ext) ? '0 : tphase_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sphase_r <= '0;
      tphase_r <= '0;
    end else begin
      sphase_r <= sphase_nxt;
      tphase_r <= tphase_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/dwdcg_back.sv
// Back end: sine table, shared serial divider, code sequencing and the output register.
`default_nettype none

module dwdcg_back import dwdcg_pkg::*; #(
  parameter int PHASE_WIDTH      = 16,
  parameter int SINE_TABLE_DEPTH = 4096
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [PERIOD_W-1:0]    sine_period,
  input  wire logic [PERIOD_W-1:0]    tri_period,
  input  wire logic                   buf_en,
  input  wire logic                   job_vld,
  input  wire logic [PHASE_WIDTH-1:0] job_phase,
  input  tri_job_t                    job_tri,
  output logic                        job_pop,
  output logic                        init_done,
  dwdcg_cmd_if.source                 out_ch
);

  localparam int AW    = $clog2(SINE_TABLE_DEPTH);
  localparam int DB    = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int SDW   = PHASE_WIDTH + DB;
  localparam int NW    = (SDW > TRI_DVD_W) ? SDW : TRI_DVD_W;
  localparam int CNT_W = $clog2(NW);

  localparam logic [NW-1:0]    DEPTH_N   = NW'(SINE_TABLE_DEPTH);
  localparam logic [AW:0]      DEPTH_M   = (AW+1)'(SINE_TABLE_DEPTH);
  localparam logic [AW-1:0]    LAST_ADDR = AW'(SINE_TABLE_DEPTH - 1);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NW - 1);

  // Fixed-point constants for building the sine table.
  localparam logic [63:0] PI_Q44    = 64'h0000_3243_F6A8_885A;
  localparam logic [63:0] Q30_ONE   = 64'd1 << 30;
  localparam logic [63:0] SINE_BASE = 64'd512 << 31;
  localparam logic [63:0] DEPTH_X1  = 64'(SINE_TABLE_DEPTH);
  localparam logic [63:0] DEPTH_X2  = DEPTH_X1 << 1;
  localparam logic [63:0] DEPTH_X3  = DEPTH_X2 + DEPTH_X1;

  // Sequencer states.
  localparam logic [2:0] ST_FILL = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_SDIV = 3'd2;
  localparam logic [2:0] ST_EMA  = 3'd3;
  localparam logic [2:0] ST_TDIV = 3'd4;
  localparam logic [2:0] ST_EMB  = 3'd5;

  // Table entry k: quarter-wave reduction, then a Q30 Taylor series up to x^15.
  function automatic logic [CODE_W-1:0] sine_entry(input int unsigned k);
    logic [63:0] k4, quad, rsd, ang, xq44, x, x2, t, prod, d, s, delta, v;
    k4 = 64'(k) << 2;
    // Quadrant and position inside it, found by comparing against whole quadrants.
    if (k4 >= DEPTH_X3) begin
      quad = 64'd3;
      rsd  = k4 - DEPTH_X3;
    end else if (k4 >= DEPTH_X2) begin
      quad = 64'd2;
      rsd  = k4 - DEPTH_X2;
    end else if (k4 >= DEPTH_X1) begin
      quad = 64'd1;
      rsd  = k4 - DEPTH_X1;
    end else begin
      quad = 64'd0;
      rsd  = k4;
    end
    ang  = quad[0] ? (DEPTH_X1 - rsd) : rsd;
    xq44 = (PI_Q44 * ang) / DEPTH_X2;
    x    = (xq44 + (64'd1 << 13)) >> 14;
    x2   = (x * x) >> 30;
    t    = Q30_ONE;
    for (int i = 0; i < 7; i++) begin
      prod = (x2 * t) >> 30;
      case (i)
        0:       d = prod / 64'd210;
        1:       d = prod / 64'd156;
        2:       d = prod / 64'd110;
        3:       d = prod / 64'd72;
        4:       d = prod / 64'd42;
        5:       d = prod / 64'd20;
        default: d = prod / 64'd6;
      endcase
      t = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
    end
    s     = (x * t) >> 30;
    delta = 64'd1023 * s;
    if (quad < 64'd2) begin
      v = (SINE_BASE + delta) >> 31;
    end else begin
      v = (delta >= SINE_BASE) ? 64'd0 : (SINE_BASE - delta) >> 31;
    end
    if (v > 64'd1023) begin
      v = 64'd1023;
    end
    return v[CODE_W-1:0];
  endfunction

  // Fixed table contents, copied into the RAM by the fill pass after reset.
  logic [CODE_W-1:0] rom_code [SINE_TABLE_DEPTH];

  for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++) begin : g_rom
    localparam logic [CODE_W-1:0] EntryCode = sine_entry(gi);
    assign rom_code[gi] = EntryCode;
  end

  logic [2:0]          state_r, state_nxt;
  logic [AW-1:0]       fill_cnt_r, fill_cnt_nxt;
  logic [NW-1:0]       dq_r, dq_nxt;
  logic [PERIOD_W-1:0] rem_r, rem_nxt;
  logic [PERIOD_W-1:0] dvs_r, dvs_nxt;
  logic [AW-1:0]       qmod_r, qmod_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  tri_job_t            tri_r, tri_nxt;

  logic                out_vld_r, out_vld_nxt;
  logic [CMD_W-1:0]    out_cmd_r, out_cmd_nxt;
  logic                out_dch_r, out_dch_nxt;
  logic [CODE_W-1:0]   out_code_r, out_code_nxt;
  logic                out_last_r, out_last_nxt;

  logic [PERIOD_W:0]   div_shift, div_diff;
  logic                div_ge;
  logic [PERIOD_W-1:0] rem_step;
  logic [AW:0]         qm2, qm_sub;
  logic [AW-1:0]       qmod_step;
  logic [NW-1:0]       sine_dvd, tri_x_ext, tri_dvd;
  logic [PERIOD_W-1:0] sine_dvs, tri_dvs;
  logic [CODE_W-1:0]   tri_code;
  logic                out_free;
  logic                ram_we, ram_re;
  logic [CODE_W-1:0]   ram_rd_data;

  // One restoring division step, with the quotient also folded modulo the table depth.
  assign div_shift = {rem_r, dq_r[NW-1]};
  assign div_diff  = div_shift - {1'b0, dvs_r};
  assign div_ge    = (div_shift >= {1'b0, dvs_r});
  assign rem_step  = div_ge ? div_diff[PERIOD_W-1:0] : div_shift[PERIOD_W-1:0];
  assign qm2       = {qmod_r, div_ge};
  assign qm_sub    = (qm2 >= DEPTH_M) ? qm2 - DEPTH_M : qm2;
  assign qmod_step = qm_sub[AW-1:0];

  // Divider operands: sine turn and triangle ramp.
  assign sine_dvd  = NW'(job_phase) * DEPTH_N;
  assign sine_dvs  = (sine_period == '0) ? PERIOD_W'(1) : sine_period;
  assign tri_x_ext = NW'(tri_r.x);
  assign tri_dvd   = tri_r.zero ? '0 : (tri_x_ext << CODE_W) - tri_x_ext;
  assign tri_dvs   = tri_r.zero ? PERIOD_W'(1)
                                : {1'b0, tri_period[PERIOD_W-1:1]} - PERIOD_W'(1);
  assign tri_code  = (|dq_r[NW-1:CODE_W]) ? CODE_MAX : dq_r[CODE_W-1:0];

  assign out_free  = !out_vld_r || out_ch.ready;
  assign init_done = (state_r != ST_FILL);

  dwdcg_ram #(
    .WIDTH (CODE_W),
    .DEPTH (SINE_TABLE_DEPTH)
  ) u_sine_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (fill_cnt_r),
    .wr_data (rom_code[fill_cnt_r]),
    .rd_en   (ram_re),
    .rd_addr (qmod_step),
    .rd_data (ram_rd_data)
  );

  // Sequencer: fill the table, then per job divide for the sine, emit, divide for the triangle, emit.
  always_comb begin
    state_nxt    = state_r;
    fill_cnt_nxt = fill_cnt_r;
    dq_nxt       = dq_r;
    rem_nxt      = rem_r;
    dvs_nxt      = dvs_r;
    qmod_nxt     = qmod_r;
    cnt_nxt      = cnt_r;
    tri_nxt      = tri_r;
    out_vld_nxt  = out_vld_r && !out_ch.ready;
    out_cmd_nxt  = out_cmd_r;
    out_dch_nxt  = out_dch_r;
    out_code_nxt = out_code_r;
    out_last_nxt = out_last_r;
    job_pop      = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;

    case (state_r)
      ST_FILL: begin
        ram_we = 1'b1;
        if (fill_cnt_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end else begin
          fill_cnt_nxt = fill_cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (job_vld) begin
          job_pop   = 1'b1;
          dq_nxt    = sine_dvd;
          dvs_nxt   = sine_dvs;
          rem_nxt   = '0;
          qmod_nxt  = '0;
          cnt_nxt   = '0;
          tri_nxt   = job_tri;
          state_nxt = ST_SDIV;
        end
      end
      ST_SDIV: begin
        dq_nxt   = {dq_r[NW-2:0], div_ge};
        rem_nxt  = rem_step;
        qmod_nxt = qmod_step;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          // The final folded quotient is the table address.
          ram_re    = 1'b1;
          state_nxt = ST_EMA;
        end
      end
      ST_EMA: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_cmd_nxt  = cmd_word(CH_SINE, buf_en, ram_rd_data);
          out_dch_nxt  = CH_SINE;
          out_code_nxt = ram_rd_data;
          out_last_nxt = 1'b0;
          dq_nxt       = tri_dvd;
          dvs_nxt      = tri_dvs;
          rem_nxt      = '0;
          cnt_nxt      = '0;
          state_nxt    = ST_TDIV;
        end
      end
      ST_TDIV: begin
        dq_nxt  = {dq_r[NW-2:0], div_ge};
        rem_nxt = rem_step;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          state_nxt = ST_EMB;
        end
      end
      ST_EMB: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_cmd_nxt  = cmd_word(CH_TRI, buf_en, tri_code);
          out_dch_nxt  = CH_TRI;
          out_code_nxt = tri_code;
          out_last_nxt = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_FILL;
      fill_cnt_r <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      fill_cnt_r <= fill_cnt_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // Datapath and output payload registers need no reset.
  always_ff @(posedge clk) begin
    dq_r       <= dq_nxt;
    rem_r      <= rem_nxt;
    dvs_r      <= dvs_nxt;
    qmod_r     <= qmod_nxt;
    cnt_r      <= cnt_nxt;
    tri_r      <= tri_nxt;
    out_cmd_r  <= out_cmd_nxt;
    out_dch_r  <= out_dch_nxt;
    out_code_r <= out_code_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.command_word = out_cmd_r;
  assign out_ch.dac_channel  = out_dch_r;
  assign out_ch.sample_code  = out_code_r;
  assign out_ch.last         = out_last_r;

  a_fill_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL) |-> !out_vld_r && !job_pop)
    else $error("output or job activity during the table fill");

  a_b_follows_a: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMB && out_free) |=> out_vld_r && out_last_r && (out_dch_r == CH_TRI))
    else $error("channel B word not presented after its load");

  a_addr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SDIV) |-> ({1'b0, qmod_r} < DEPTH_M))
    else $error("folded sine turn outside the table");

endmodule

`default_nettype wire

### rtl/dual_waveform_dac_command_generator_top.sv
// Top level of the dual waveform DAC command generator: configuration registers and wiring.
//
// Every accepted word with the tick bit set yields two DAC command words, channel A
// (sine code) first and channel B (triangle code) second, marked by last; a word with
// the tick bit low is taken and produces nothing. The back end uses a one-bit-per-cycle
// divider of N = max(PHASE_WIDTH + clog2(SINE_TABLE_DEPTH+1), 26) steps that is shared
// between the sine turn and the triangle ramp. A two-entry job queue lets the front take
// ticks while the back is busy. After reset the sine table RAM is filled one entry per
// cycle, so no tick is taken until all SINE_TABLE_DEPTH entries (4096 by default) are
// written; configuration writes are taken at any time and must only be made while no
// tick is in flight.
`default_nettype none

module dual_waveform_dac_command_generator_top import dwdcg_pkg::*; #(
  parameter int PHASE_WIDTH      = 16,
  parameter int SINE_TABLE_DEPTH = 4096
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  dwdcg_tick_if.sink  in_ch,
  dwdcg_cmd_if.source out_ch,
  dwdcg_cfg_if.sink   cfg_ch
);

  localparam int JOB_W = PHASE_WIDTH + $bits(tri_job_t);

  logic [PERIOD_W-1:0]    sine_period_r, sine_period_nxt;
  logic [PERIOD_W-1:0]    tri_period_r, tri_period_nxt;
  logic                   buf_en_r, buf_en_nxt;

  logic                   init_done;
  logic                   q_full, q_push, q_pop, q_not_empty;
  logic [PHASE_WIDTH-1:0] push_phase;
  tri_job_t               push_tri;
  logic [JOB_W-1:0]       pop_data;

  // Configuration writes are always taken; unknown indexes are ignored.
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    sine_period_nxt = sine_period_r;
    tri_period_nxt  = tri_period_r;
    buf_en_nxt      = buf_en_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_SINE_PERIOD: sine_period_nxt = cfg_ch.data;
        REG_TRI_PERIOD:  tri_period_nxt  = cfg_ch.data;
        REG_BUF_EN:      buf_en_nxt      = cfg_ch.data[0];
        default:         buf_en_nxt      = buf_en_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sine_period_r <= SINE_PERIOD_RST;
      tri_period_r  <= TRI_PERIOD_RST;
      buf_en_r      <= 1'b0;
    end else begin
      sine_period_r <= sine_period_nxt;
      tri_period_r  <= tri_period_nxt;
      buf_en_r      <= buf_en_nxt;
    end
  end

  dwdcg_front #(
    .PHASE_WIDTH (PHASE_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .sine_period (sine_period_r),
    .tri_period  (tri_period_r),
    .init_done   (init_done),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_phase     (push_phase),
    .q_tri       (push_tri)
  );

  dwdcg_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({push_tri, push_phase}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .not_empty (q_not_empty)
  );

  dwdcg_back #(
    .PHASE_WIDTH      (PHASE_WIDTH),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .sine_period (sine_period_r),
    .tri_period  (tri_period_r),
    .buf_en      (buf_en_r),
    .job_vld     (q_not_empty),
    .job_phase   (pop_data[PHASE_WIDTH-1:0]),
    .job_tri     (tri_job_t'(pop_data[JOB_W-1:PHASE_WIDTH])),
    .job_pop     (q_pop),
    .init_done   (init_done),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire

### test/tb_top.sv
// Self-checking testbench for the dual waveform DAC command generator.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dwdcg_pkg::*;

  typedef longint unsigned u64_t;

  // One DAC command word as it leaves the block.
  typedef struct packed {
    logic [CMD_W-1:0]  command_word;
    logic              dac_channel;
    logic [CODE_W-1:0] sample_code;
    logic              last;
  } dac_word_t;

  localparam int   TABLE_SIZE    = 4096;
  localparam int   TICK_TARGET   = 1650;
  // Two queued ticks plus the one in the back end, with margin.
  localparam int   SETTLE_CYCLES = 200;
  localparam int   CYCLE_LIMIT   = 1_500_000;
  localparam int   MAX_SHOWN     = 40;
  localparam u64_t Q30_ONE       = 64'd1 << 30;
  localparam u64_t PI_Q44        = 64'h3243F6A8885A;

  logic clk = 1'b0;
  logic rst_n;

  dwdcg_tick_if tick_bus ();
  dwdcg_cmd_if  word_bus ();
  dwdcg_cfg_if  reg_bus ();

  dual_waveform_dac_command_generator_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (tick_bus),
    .out_ch (word_bus),
    .cfg_ch (reg_bus)
  );

  always #4 clk = ~clk;

  // Predicted register contents and phase counters.
  logic [PERIOD_W-1:0] sine_period_cfg;
  logic [PERIOD_W-1:0] tri_period_cfg;
  logic                buffer_cfg;
  logic [15:0]         sine_pos;
  logic [15:0]         tri_phase;
  logic [CODE_W-1:0]   sine_codes [TABLE_SIZE];

  dac_word_t   pending_words [$];
  int unsigned ticks_sent;
  int unsigned mismatches;
  int unsigned burst_left;
  int unsigned cycle_count;
  int unsigned stall_left;
  int unsigned stall_mode;
  dac_word_t   want;

  // Quarter-wave sine in Q30 by a nested Taylor series up to x^15.
  function automatic u64_t sine_fraction(input u64_t x);
    u64_t divisor [7];
    u64_t x2, t, d;
    divisor = '{210, 156, 110, 72, 42, 20, 6};
    x2 = (x * x) >> 30;
    t = Q30_ONE;
    for (int i = 0; i < 7; i++) begin
      d = ((x2 * t) >> 30) / divisor[i];
      t = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
    end
    return (x * t) >> 30;
  endfunction

  // Table code for one step of the full turn, rounded half up about mid-scale.
  function automatic logic [CODE_W-1:0] sine_point(input u64_t k);
    u64_t k4, q, r, a, xq44, x, s, base, delta, v;
    k4 = 4 * k;
    q = (k4 / TABLE_SIZE) & 3;
    r = k4 % TABLE_SIZE;
    a = q[0] ? TABLE_SIZE - r : r;
    xq44 = (PI_Q44 * a) / (2 * TABLE_SIZE);
    x = (xq44 + (64'd1 << 13)) >> 14;
    s = sine_fraction(x);
    base = 64'd512 << 31;
    delta = 64'd1023 * s;
    if (q < 2) begin
      v = (base + delta) >> 31;
    end else begin
      v = (delta >= base) ? 64'd0 : (base - delta) >> 31;
    end
    if (v > CODE_MAX) v = CODE_MAX;
    return v[CODE_W-1:0];
  endfunction

  // Next phase: wraps to zero at the period or on leaving 16 bits.
  function automatic logic [15:0] next_phase(input logic [15:0] phase,
                                             input logic [PERIOD_W-1:0] period);
    logic [15:0] nx;
    nx = phase + 16'd1;
    return (nx >= period) ? 16'd0 : nx;
  endfunction

  // Work out both words of one tick and advance the phases.
  function automatic void compute_dac_words();
    u64_t      p, turn, half, tp, tph, ramp;
    logic [CODE_W-1:0] a_code, b_code;
    dac_word_t w;
    p = (sine_period_cfg == 0) ? 64'd1 : u64_t'(sine_period_cfg);
    turn = (u64_t'(sine_pos) * TABLE_SIZE) / p;
    a_code = sine_codes[turn % TABLE_SIZE];
    tp = tri_period_cfg;
    tph = tri_phase;
    half = tp / 2;
    if (half < 2 || tph >= tp) begin
      b_code = '0;
    end else begin
      if (tph < half) ramp = (tph * 1023) / (half - 1);
      else ramp = ((tp - 1 - tph) * 1023) / (half - 1);
      b_code = (ramp > CODE_MAX) ? CODE_MAX : ramp[CODE_W-1:0];
    end
    w.command_word = {CH_SINE, buffer_cfg, 2'b11, a_code, 2'b00};
    w.dac_channel  = CH_SINE;
    w.sample_code  = a_code;
    w.last         = 1'b0;
    pending_words.push_back(w);
    w.command_word = {CH_TRI, buffer_cfg, 2'b11, b_code, 2'b00};
    w.dac_channel  = CH_TRI;
    w.sample_code  = b_code;
    w.last         = 1'b1;
    pending_words.push_back(w);
    sine_pos  = next_phase(sine_pos, sine_period_cfg);
    tri_phase = next_phase(tri_phase, tri_period_cfg);
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_SHOWN) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Send one tick word; valid stays high while the burst goes on.
  task automatic send_tick(input logic t);
    tick_bus.valid <= 1'b1;
    tick_bus.tick  <= t;
    do @(posedge clk); while (!tick_bus.ready);
    ticks_sent++;
    if (t) begin
      compute_dac_words();
    end
    if (burst_left == 0) begin
      tick_bus.valid <= 1'b0;
      repeat (($urandom_range(0, 5) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 6))
        @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 50) : $urandom_range(0, 6);
    end else begin
      burst_left--;
    end
  endtask

  // Hold the sender until every expected word is back and the queue has emptied.
  task automatic wait_drained();
    tick_bus.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    reg_bus.valid <= 1'b1;
    reg_bus.index <= idx;
    reg_bus.data  <= d;
    do @(posedge clk); while (!reg_bus.ready);
    case (idx)
      REG_SINE_PERIOD: sine_period_cfg = d;
      REG_TRI_PERIOD:  tri_period_cfg  = d;
      REG_BUF_EN:      buffer_cfg      = d[0];
      default: ;
    endcase
  endtask

  // Write all three registers once the block has gone idle.
  task automatic configure(input logic [PERIOD_W-1:0] sp, input logic [PERIOD_W-1:0] tp,
                           input logic be);
    wait_drained();
    write_reg(REG_SINE_PERIOD, sp);
    write_reg(REG_TRI_PERIOD, tp);
    write_reg(REG_BUF_EN, {15'($urandom), be});
    reg_bus.valid <= 1'b0;
  endtask

  // Mostly short periods so that wraps and peaks come often.
  function automatic logic [PERIOD_W-1:0] pick_period();
    case ($urandom_range(0, 11))
      0:       return 16'($urandom_range(0, 3));
      1:       return ($urandom_range(0, 1) != 0) ? 16'd4 : 16'hFFFF;
      2, 3:    return 16'($urandom);
      4, 5:    return 16'($urandom_range(81, 5000));
      default: return 16'($urandom_range(4, 80));
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
  endtask

  task automatic test_extreme_periods();
    configure(16'd4, 16'd4, 1'b1);
    repeat (4) send_tick(1'b1);
    configure(16'hFFFF, 16'hFFFF, 1'b0);
    repeat (2) send_tick(1'b1);
  endtask

  // Sine period of zero and triangle periods too short for a ramp.
  task automatic test_degenerate_periods();
    configure(16'd0, 16'd3, 1'b1);
    repeat (2) send_tick(1'b1);
    configure(16'd1, 16'd2, 1'b0);
    repeat (2) send_tick(1'b1);
    configure(16'd3, 16'd0, 1'b1);
    send_tick(1'b1);
    configure(16'd2, 16'd1, 1'b0);
    send_tick(1'b1);
  endtask

  // The peak of an odd triangle period overshoots and must saturate.
  task automatic test_odd_triangle_peak();
    configure(16'd9, 16'd7, 1'b1);
    repeat (4) send_tick(1'b1);
  endtask

  // Shrinking the periods below the current phases wraps the turn past the table.
  task automatic test_shrunk_period();
    configure(16'd10, 16'd10, 1'b0);
    repeat (5) send_tick(1'b1);
    configure(16'd4, 16'd4, 1'b1);
    repeat (2) send_tick(1'b1);
  endtask

  task automatic test_random_traffic();
    int unsigned phase_len;
    while (ticks_sent < TICK_TARGET) begin
      configure(pick_period(), pick_period(), 1'($urandom));
      phase_len = $urandom_range(20, 120);
      for (int k = 0; k < phase_len; k++) begin
        send_tick($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 99) == 0) wait_drained();
      end
    end
  endtask

  // Receiver: switches between always ready and several stall densities.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(30, 300);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       word_bus.ready <= 1'b1;
      1:       word_bus.ready <= 1'($urandom_range(0, 1));
      2:       word_bus.ready <= ($urandom_range(0, 3) == 0);
      default: word_bus.ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Compare each accepted word with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && word_bus.valid && word_bus.ready) begin
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", word_bus.command_word));
      end else begin
        want = pending_words.pop_front();
        if (word_bus.command_word !== want.command_word)
          report_mismatch($sformatf("command_word %h, expected %h",
                                    word_bus.command_word, want.command_word));
        if (word_bus.dac_channel !== want.dac_channel)
          report_mismatch($sformatf("dac_channel %b, expected %b",
                                    word_bus.dac_channel, want.dac_channel));
        if (word_bus.sample_code !== want.sample_code)
          report_mismatch($sformatf("sample_code %0d, expected %0d",
                                    word_bus.sample_code, want.sample_code));
        if (word_bus.last !== want.last)
          report_mismatch($sformatf("last %b, expected %b", word_bus.last, want.last));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    tick_bus.valid = 1'b0;
    tick_bus.tick  = 1'b0;
    reg_bus.valid  = 1'b0;
    reg_bus.index  = REG_SINE_PERIOD;
    reg_bus.data   = '0;
    word_bus.ready = 1'b0;
    rst_n          = 1'b0;
    ticks_sent     = 0;
    mismatches     = 0;
    cycle_count    = 0;
    stall_left     = 0;
    stall_mode     = 0;
    burst_left     = $urandom_range(0, 6);
    for (int k = 0; k < TABLE_SIZE; k++) sine_codes[k] = sine_point(k);
    sine_period_cfg = SINE_PERIOD_RST;
    tri_period_cfg  = TRI_PERIOD_RST;
    buffer_cfg      = 1'b0;
    sine_pos        = '0;
    tri_phase       = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_extreme_periods();
    test_degenerate_periods();
    test_odd_triangle_peak();
    test_shrunk_period();
    test_random_traffic();
    wait_drained();

    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
rtl/dwdcg_pkg.sv
rtl/dwdcg_if.sv
rtl/dwdcg_ram.sv
rtl/dwdcg_queue.sv
rtl/dwdcg_front.sv
rtl/dwdcg_back.sv
rtl/dual_waveform_dac_command_generator_top.sv
test/tb_top.sv
